[rtl/core/assert_macros.svh]
// Assertion macros for the stereo feedback delay core.
// Used by files that check their own logic; empty when SYNTHESIS is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SFD_ASSERT_IMP(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");
`define SFD_ASSERT_NXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");
`else
`define SFD_ASSERT_IMP(lbl, clk, rst_n, a, b)
`define SFD_ASSERT_NXT(lbl, clk, rst_n, a, b)
`endif
`endif

[rtl/core/sfd_pkg.sv]
// Package for the stereo feedback delay: sizes, register indexes, lane control struct
// and the Q1.15 round-and-saturate function. No dependencies.
`timescale 1ns / 1ps
package sfd_pkg;

	localparam int RING_DEPTH  = 131072;
	localparam int SAMPLE_BITS = 16;
	localparam int ADDR_W      = $clog2(RING_DEPTH);
	localparam int LEN_W       = $clog2(RING_DEPTH + 1);

	localparam int LEN_CFG_W   = 18;
	localparam int DELAY_CFG_W = 17;
	localparam int GAIN_W      = 16;
	localparam int CFG_DATA_W  = 18;
	localparam int CFG_IDX_W   = 3;

	localparam int FRAC       = 15;
	localparam int ROUND_HALF = 1 << (FRAC - 1);
	localparam int PROD_W     = SAMPLE_BITS + GAIN_W + 1;
	localparam int ACC_W      = PROD_W + 1;
	localparam int RND_W      = ACC_W - FRAC;

	localparam logic [CFG_IDX_W-1:0] REG_RING_LENGTH = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_DELAY       = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK    = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_DRY         = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_WET         = CFG_IDX_W'(4);

	localparam logic [LEN_CFG_W-1:0]   RING_LENGTH_RST = LEN_CFG_W'(96000);
	localparam logic [DELAY_CFG_W-1:0] DELAY_RST       = '0;
	localparam logic [GAIN_W-1:0]      FEEDBACK_RST    = '0;
	localparam logic [GAIN_W-1:0]      DRY_RST         = GAIN_W'(32768);
	localparam logic [GAIN_W-1:0]      WET_RST         = GAIN_W'(32768);

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	typedef struct packed {
		logic [GAIN_W-1:0] feedback;
		logic [GAIN_W-1:0] dry;
		logic [GAIN_W-1:0] wet;
	} gains_t;

	typedef struct packed {
		logic              en;
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic              fresh_s2;
		logic              fwd_s2;
		logic              unwritten_s2;
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic              v_s3;
	} lane_ctl_t;

	// round half up (add 2^14, drop the 15 fraction bits), then clamp to the sample range
	function automatic sample_t round_sat(input logic signed [ACC_W-1:0] acc);
		logic signed [ACC_W-1:0] biased;
		logic signed [RND_W-1:0] r;
		sample_t                 res;
		biased = acc + ACC_W'(ROUND_HALF);
		r      = $signed(biased[ACC_W-1:FRAC]);
		if (r > RND_W'(SAMPLE_MAX)) begin
			res = SAMPLE_MAX;
		end else if (r < RND_W'(SAMPLE_MIN)) begin
			res = SAMPLE_MIN;
		end else begin
			res = r[SAMPLE_BITS-1:0];
		end
		return res;
	endfunction

endpackage

[rtl/core/sfd_ram.sv]
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module sfd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/core/sfd_ctrl.sv]
// Shared control for the delay lanes: config registers, write position, ring clamps,
// read address and hazard flags. Depends on sfd_pkg.
`timescale 1ns / 1ps
module sfd_ctrl (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [sfd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sfd_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             en,
	input  logic                             accept,
	output sfd_pkg::gains_t                  gains,
	output sfd_pkg::lane_ctl_t               ctl
);
	import sfd_pkg::*;

	logic [LEN_CFG_W-1:0]   ring_length_q;
	logic [DELAY_CFG_W-1:0] delay_q;
	logic [GAIN_W-1:0]      feedback_q;
	logic [GAIN_W-1:0]      dry_q;
	logic [GAIN_W-1:0]      wet_q;

	logic [ADDR_W-1:0] wr_idx_q;
	logic [LEN_W-1:0]  hw_q;
	logic              v_s1, v_s2, v_s3;

	logic [LEN_W-1:0]  len_eff;
	logic [ADDR_W-1:0] d_eff;
	logic [ADDR_W-1:0] pos;
	logic [LEN_W-1:0]  pos_inc;
	logic [ADDR_W-1:0] next_idx;

	logic [ADDR_W-1:0] pos_s1, d_s1;
	logic [LEN_W-1:0]  len_s1, hw_s1;
	logic [ADDR_W-1:0] rd_s1;
	logic              fresh_s1, unwritten_s1;

	logic [ADDR_W-1:0] pos_s2, rd_s2;
	logic              fresh_s2, unwritten_s2;
	logic [ADDR_W-1:0] pos_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_length_q <= RING_LENGTH_RST;
			delay_q       <= DELAY_RST;
			feedback_q    <= FEEDBACK_RST;
			dry_q         <= DRY_RST;
			wet_q         <= WET_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RING_LENGTH: ring_length_q <= cfg_data[LEN_CFG_W-1:0];
				REG_DELAY:       delay_q       <= cfg_data[DELAY_CFG_W-1:0];
				REG_FEEDBACK:    feedback_q    <= cfg_data[GAIN_W-1:0];
				REG_DRY:         dry_q         <= cfg_data[GAIN_W-1:0];
				REG_WET:         wet_q         <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// clamps: zero length acts as one, length above RING_DEPTH acts as RING_DEPTH, delay kept below length
	always_comb begin
		if (ring_length_q == '0) begin
			len_eff = LEN_W'(1);
		end else if (32'(ring_length_q) > 32'(RING_DEPTH)) begin
			len_eff = LEN_W'(RING_DEPTH);
		end else begin
			len_eff = LEN_W'(ring_length_q);
		end
		if (32'(delay_q) >= 32'(len_eff)) begin
			d_eff = ADDR_W'(len_eff - LEN_W'(1));
		end else begin
			d_eff = ADDR_W'(delay_q);
		end
		pos      = (LEN_W'(wr_idx_q) >= len_eff) ? '0 : wr_idx_q;
		pos_inc  = LEN_W'(pos) + LEN_W'(1);
		next_idx = (pos_inc >= len_eff) ? '0 : ADDR_W'(pos_inc);
	end

	always_comb begin
		if (pos_s1 >= d_s1) begin
			rd_s1 = pos_s1 - d_s1;
		end else begin
			rd_s1 = ADDR_W'(LEN_W'(pos_s1) + len_s1 - LEN_W'(d_s1));
		end
		fresh_s1     = (d_s1 == '0);
		unwritten_s1 = (LEN_W'(rd_s1) >= hw_s1);
	end

	// hw_q: positions below it have been written since reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q <= '0;
			hw_q     <= '0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
		end else if (en) begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (accept) begin
				wr_idx_q <= next_idx;
				if (pos_inc > hw_q) begin
					hw_q <= pos_inc;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pos_s1       <= pos;
			d_s1         <= d_eff;
			len_s1       <= len_eff;
			hw_s1        <= hw_q;
			pos_s2       <= pos_s1;
			rd_s2        <= rd_s1;
			fresh_s2     <= fresh_s1;
			unwritten_s2 <= unwritten_s1;
			pos_s3       <= pos_s2;
		end
	end

	assign gains.feedback = feedback_q;
	assign gains.dry      = dry_q;
	assign gains.wet      = wet_q;

	// the item one stage ahead wrote in the cycle of our read: forward it
	assign ctl.en           = en;
	assign ctl.rd_en        = en;
	assign ctl.rd_addr      = rd_s1;
	assign ctl.fresh_s2     = fresh_s2;
	assign ctl.fwd_s2       = v_s3 && (pos_s3 == rd_s2);
	assign ctl.unwritten_s2 = unwritten_s2;
	assign ctl.wr_en        = en && v_s2;
	assign ctl.wr_addr      = pos_s2;
	assign ctl.v_s3         = v_s3;

endmodule

[rtl/core/sfd_lane.sv]
// One channel of the delay: ring RAM, feedback write-back and dry/wet mix pipeline.
// Depends on sfd_pkg and sfd_ram.
`timescale 1ns / 1ps
module sfd_lane (
	input  logic                clk,
	input  sfd_pkg::lane_ctl_t  ctl,
	input  sfd_pkg::gains_t     gains,
	input  sfd_pkg::sample_t    sample_in,
	output sfd_pkg::sample_t    sample_out
);
	import sfd_pkg::*;

	sample_t x_s1, x_s2;
	sample_t delayed_s2;
	sample_t wb_s2, wb_s3;
	logic [SAMPLE_BITS-1:0] ram_rdata;

	logic signed [PROD_W-1:0] fb_prod_s2;
	logic signed [PROD_W-1:0] dry_prod_s2, wet_prod_s2;
	logic signed [PROD_W-1:0] dry_s3, wet_s3;
	logic signed [ACC_W-1:0]  fb_acc_s2;
	logic signed [ACC_W-1:0]  mix_acc_s3;

	sfd_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(RING_DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (ctl.wr_en),
		.waddr(ctl.wr_addr),
		.wdata(wb_s2),
		.re   (ctl.rd_en),
		.raddr(ctl.rd_addr),
		.rdata(ram_rdata)
	);

	always_comb begin
		if (ctl.fresh_s2) begin
			delayed_s2 = x_s2;
		end else if (ctl.fwd_s2) begin
			delayed_s2 = wb_s3;
		end else if (ctl.unwritten_s2) begin
			delayed_s2 = '0;
		end else begin
			delayed_s2 = $signed(ram_rdata);
		end
		fb_prod_s2  = $signed({1'b0, gains.feedback}) * delayed_s2;
		fb_acc_s2   = ACC_W'(fb_prod_s2) + (ACC_W'(x_s2) <<< FRAC);
		wb_s2       = round_sat(fb_acc_s2);
		dry_prod_s2 = $signed({1'b0, gains.dry}) * x_s2;
		wet_prod_s2 = $signed({1'b0, gains.wet}) * delayed_s2;
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			x_s1   <= sample_in;
			x_s2   <= x_s1;
			wb_s3  <= wb_s2;
			dry_s3 <= dry_prod_s2;
			wet_s3 <= wet_prod_s2;
		end
	end

	assign mix_acc_s3 = ACC_W'(dry_s3) + ACC_W'(wet_s3);
	assign sample_out = round_sat(mix_acc_s3);

endmodule

[rtl/core/stereo_feedback_delay_top.sv]
// Stereo feedback delay (echo): one stereo sample in and one mixed stereo sample out per
// transfer, with feedback into a 131072-entry ring per channel. Takes one input transfer
// every cycle while the output is not stalled; the result passes stages s1, s2, s3 and
// is offered from an output register. While an offered result is not taken the whole
// pipeline holds and in_ready is low. The rate is set by each lane's ring RAM, read and
// written once per item, with the feedback multiply, add and saturation done in one stage
// so an item may use the entry its predecessor wrote. Ring contents are not cleared: a
// high-water mark of written positions makes untouched entries read as zero, so the block
// is ready straight after reset. Depends on sfd_pkg, sfd_ctrl, sfd_lane.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module stereo_feedback_delay_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic signed [sfd_pkg::SAMPLE_BITS-1:0] left_in,
	input  logic signed [sfd_pkg::SAMPLE_BITS-1:0] right_in,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [sfd_pkg::SAMPLE_BITS-1:0] left_out,
	output logic signed [sfd_pkg::SAMPLE_BITS-1:0] right_out,
	input  logic                             cfg_we,
	input  logic [sfd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sfd_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import sfd_pkg::*;

	logic      en;
	logic      accept;
	gains_t    gains;
	lane_ctl_t ctl;
	sample_t   left_s3, right_s3;
	logic      out_valid_q;
	sample_t   left_q, right_q;

	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;
	assign accept   = in_valid && en;

	sfd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.en       (en),
		.accept   (accept),
		.gains    (gains),
		.ctl      (ctl)
	);

	sfd_lane u_lane_left (
		.clk       (clk),
		.ctl       (ctl),
		.gains     (gains),
		.sample_in (left_in),
		.sample_out(left_s3)
	);

	sfd_lane u_lane_right (
		.clk       (clk),
		.ctl       (ctl),
		.gains     (gains),
		.sample_in (right_in),
		.sample_out(right_s3)
	);

	// merge: both lanes land in one output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= ctl.v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			left_q  <= left_s3;
			right_q <= right_s3;
		end
	end

	assign out_valid = out_valid_q;
	assign left_out  = left_q;
	assign right_out = right_q;

	`SFD_ASSERT_IMP(a_no_ring_write_stalled, clk, arst_n, out_valid && !out_ready, !ctl.wr_en)
	`SFD_ASSERT_IMP(a_ready_falls_on_full, clk, arst_n, $fell(in_ready), out_valid)
	`SFD_ASSERT_IMP(a_result_from_pipe, clk, arst_n, $rose(out_valid), $past(ctl.v_s3))

endmodule
